[rtl/core/tone_generator_with_envelope_defines.svh]
// Assertion macros shared by the tone generator RTL.
`ifndef TONE_GENERATOR_WITH_ENVELOPE_DEFINES_SVH
`define TONE_GENERATOR_WITH_ENVELOPE_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, quiet during reset.
`define TGE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, quiet during reset.
`define TGE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tge_pkg.sv]
package tge_pkg;

    // Fixed field widths.
    localparam int FRAME_BITS  = 20;
    localparam int SAMPLE_BITS = 16;

    // Input word: start or tick.
    typedef struct packed {
        logic                  kind;
        logic [FRAME_BITS-1:0] note_frames;
        logic [31:0]           noise_seed;
    } t_in;

    // Output word: one sample.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_out;

    // Command and response of the serial multiply-divide unit.
    typedef struct packed {
        logic        go;
        logic        div;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] d;
    } t_md_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] p;
    } t_md_rsp;

    // Input kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WAVE_SHAPE    = 3'd0;
    localparam logic [2:0] CFG_START_STEP    = 3'd1;
    localparam logic [2:0] CFG_END_STEP      = 3'd2;
    localparam logic [2:0] CFG_AMPLITUDE     = 3'd3;
    localparam logic [2:0] CFG_ATTACK        = 3'd4;
    localparam logic [2:0] CFG_DECAY         = 3'd5;
    localparam logic [2:0] CFG_SUSTAIN       = 3'd6;
    localparam logic [2:0] CFG_RELEASE       = 3'd7;

    // Wave shapes.
    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
    localparam logic [2:0] SHAPE_SAW      = 3'd3;
    localparam logic [2:0] SHAPE_NOISE    = 3'd4;

    // Arithmetic constants.
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] NOISE_HALF = 32'h007F_FFFF;
    localparam logic [16:0] UNITY_Q15  = 17'd32768;

endpackage

[rtl/core/tge_muldiv.sv]
// Bit-serial unit: a * b over 32 steps, then optionally that product
// divided by d over 64 restoring steps. One bit is handled per cycle.
module tge_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tge_pkg::t_md_cmd i_cmd,
    output tge_pkg::t_md_rsp o_rsp
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;

    logic [1:0]  r_mode;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic        r_div;
    logic [31:0] r_a;
    logic [31:0] r_d;
    logic [63:0] r_p;
    logic [31:0] r_rem;

    logic [32:0] n_sum;
    logic [32:0] n_rr;
    logic        n_fit;

    // One shift-add step and one restoring divide step.
    always_comb begin
        n_sum = {1'b0, r_p[63:32]} + (r_p[0] ? {1'b0, r_a} : 33'd0);
        n_rr  = {r_rem, r_p[63]};
        n_fit = (n_rr >= {1'b0, r_d});
    end

    // Sequencing of the two phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_IDLE;
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_mode)
                MD_IDLE: begin
                    if (i_cmd.go) begin
                        r_mode <= MD_MUL;
                        r_cnt  <= 6'd0;
                    end
                end
                MD_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_cnt <= 6'd0;
                        if (r_div) begin
                            r_mode <= MD_DIV;
                        end else begin
                            r_mode <= MD_IDLE;
                            r_done <= 1'b1;
                        end
                    end
                end
                MD_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_mode <= MD_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_mode <= MD_IDLE;
            endcase
        end
    end

    // Operand and product registers.
    always_ff @(posedge i_clk) begin
        case (r_mode)
            MD_IDLE: begin
                if (i_cmd.go) begin
                    r_a   <= i_cmd.a;
                    r_d   <= i_cmd.d;
                    r_div <= i_cmd.div;
                    r_p   <= {32'd0, i_cmd.b};
                    r_rem <= 32'd0;
                end
            end
            MD_MUL: r_p <= {n_sum, r_p[31:1]};
            MD_DIV: begin
                if (n_fit) begin
                    r_rem <= 32'(n_rr - {1'b0, r_d});
                    r_p   <= {r_p[62:0], 1'b1};
                end else begin
                    r_rem <= n_rr[31:0];
                    r_p   <= {r_p[62:0], 1'b0};
                end
            end
            default: r_p <= r_p;
        endcase
    end

    assign o_rsp.busy = (r_mode != MD_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

[rtl/core/tge_sine_rom.sv]
// Full-wave sine table with a registered read port. Contents are worked
// out at elaboration with a Q30 Taylor series on a quarter wave.
module tge_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output logic signed [16:0]       o_data
);

    typedef logic signed [16:0] t_sine_tab [DEPTH];

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned FS          = 64'd32768;
    localparam longint unsigned HORNER_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    function automatic t_sine_tab build_sine();
        t_sine_tab       tab;
        longint unsigned u;
        longint unsigned quad;
        longint unsigned t;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned p;
        longint unsigned s;
        longint unsigned mag;
        for (int k = 0; k < DEPTH; k++) begin
            u    = 64'(4 * k);
            quad = u / DEPTH;
            t    = ((u % DEPTH) << 30) / DEPTH;
            if (quad[0]) begin
                t = Q30_ONE - t;
            end
            y  = (t * HALF_PI_Q30) >> 30;
            y2 = (y * y) >> 30;
            p  = Q30_ONE;
            for (int i = 0; i < 5; i++) begin
                p = Q30_ONE - ((y2 * p) >> 30) / HORNER_DIV[i];
            end
            s   = (y * p) >> 30;
            mag = (s * FS + 64'd536870912) >> 30;
            if (mag > FS) begin
                mag = FS;
            end
            tab[k] = (quad >= 64'd2) ? -17'(mag) : 17'(mag);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_data <= SINE_TAB[i_addr];
    end

endmodule

[rtl/core/tone_generator_with_envelope.sv]
// Tone generator with an attack/decay/sustain/release envelope.
// Input channel (i_in_valid/o_in_ready, word i_in_data): a start word arms
// a note of note_frames frames and loads the noise seed; a tick word makes
// the next sample of the armed note, and a tick with no note makes nothing.
// Output channel (o_out_valid/i_out_ready, word o_out_data): one signed
// Q1.15 sample per tick, with last set on the final frame of the note.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready; the user must write it only while the block is idle, as the
// block itself does not enforce this. A start word is taken straight from idle.
// A tick runs through one bit-serial multiply-divide unit: sweep, envelope and
// two gain products, and with noise a generator product and a noise division
// before the envelope. Each operation is a product, optionally with a division.
// The input is ready again as soon as a sample is in the output register;
// if the receiver stalls, the next tick finishes its work and waits for
// that register to empty. Reset clears the note, the phase, the frame
// count and the configuration (sustain level to 1.0), and sets noise to 1.
`include "tone_generator_with_envelope_defines.svh"

module tone_generator_with_envelope #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tge_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tge_pkg::t_out  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    localparam logic [2:0] OP_SWEEP = 3'd0;
    localparam logic [2:0] OP_LCG   = 3'd1;
    localparam logic [2:0] OP_NOISE = 3'd2;
    localparam logic [2:0] OP_ENV   = 3'd3;
    localparam logic [2:0] OP_MUL1  = 3'd4;
    localparam logic [2:0] OP_MUL2  = 3'd5;

    // Configuration registers.
    logic [2:0]  r_shape;
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [15:0] r_amp;
    logic [19:0] r_att;
    logic [19:0] r_dec;
    logic [15:0] r_sus;
    logic [19:0] r_rel;

    // Note state and sequencer.
    logic [1:0]  r_state;
    logic [2:0]  r_op;
    logic        r_active;
    logic [19:0] r_f;
    logic [19:0] r_len;
    logic [31:0] r_phase;
    logic [31:0] r_noise;
    logic        r_out_valid;

    // Working values.
    logic [16:0] r_nq;
    logic [16:0] r_g;
    logic [16:0] r_env_base;
    logic        r_env_sub;
    logic [31:0] r_p1;
    logic        r_wneg;
    logic [15:0] r_smp;
    tge_pkg::t_out r_out_data;

    tge_pkg::t_md_cmd w_cmd;
    tge_pkg::t_md_rsp w_rsp;
    logic signed [16:0] w_rom;

    logic        n_up;
    logic [31:0] n_diff;
    logic [31:0] n_step;
    logic [17:0] n_wave;
    logic [16:0] n_wabs;
    logic [29:0] n_tri_a;
    logic [30:0] n_tri_m;
    logic [20:0] n_a_plus_d;
    logic [19:0] n_rel_start;
    logic        n_att_hit;
    logic        n_dec_hit;
    logic        n_sus_hit;
    logic        n_rel_hit;
    logic [16:0] n_dec_amt;
    logic [33:0] n_mag_full;
    logic [15:0] n_mag;
    logic [15:0] n_smp;
    logic [20:0] n_f_inc;
    logic        n_last;
    logic [16:0] n_gain;

    tge_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    tge_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (r_phase[31 -: ADDR_W]),
        .o_data (w_rom)
    );

    // Frequency sweep: step moves from start to end over the note.
    always_comb begin
        n_up   = (r_end >= r_start);
        n_diff = n_up ? (r_end - r_start) : (r_start - r_end);
        n_step = n_up ? (r_start + w_rsp.p[31:0]) : (r_start - w_rsp.p[31:0]);
    end

    // Waveform value from the current phase.
    always_comb begin
        n_tri_a = r_phase[29:0];
        n_tri_m = r_phase[30] ? (31'h4000_0000 - {1'b0, n_tri_a}) : {1'b0, n_tri_a};
        case (r_shape)
            tge_pkg::SHAPE_SINE:     n_wave = {w_rom[16], w_rom};
            tge_pkg::SHAPE_SQUARE:   n_wave = r_phase[31] ? 18'h3_8000 : 18'h0_8000;
            tge_pkg::SHAPE_TRIANGLE: n_wave = r_phase[31] ? (18'd0 - {2'b00, n_tri_m[30:15]})
                                                          : {2'b00, n_tri_m[30:15]};
            tge_pkg::SHAPE_SAW:      n_wave = {{2{r_phase[31]}}, r_phase[31:16]};
            tge_pkg::SHAPE_NOISE:    n_wave = {1'b0, r_nq} - 18'd32768;
            default:                 n_wave = 18'd0;
        endcase
        n_wabs = n_wave[17] ? 17'(18'd0 - n_wave) : n_wave[16:0];
    end

    // Envelope stage selection for the current frame.
    always_comb begin
        n_a_plus_d  = {1'b0, r_att} + {1'b0, r_dec};
        n_rel_start = (r_len > r_rel) ? (r_len - r_rel) : 20'd0;
        n_att_hit   = (r_att != 20'd0) && (r_f < r_att);
        n_dec_hit   = (r_dec != 20'd0) && ({1'b0, r_f} < n_a_plus_d);
        n_sus_hit   = (r_f < n_rel_start);
        n_rel_hit   = (r_len > n_rel_start) && (r_f < r_len);
        n_dec_amt   = r_sus[15] ? {1'b0, r_sus - 16'h8000}
                                : (tge_pkg::UNITY_Q15 - {1'b0, r_sus});
        n_gain      = r_env_sub ? (r_env_base - w_rsp.p[16:0])
                                : (r_env_base + w_rsp.p[16:0]);
    end

    // Command to the multiply-divide unit for each operation.
    always_comb begin
        w_cmd.go  = (r_state == S_ISSUE);
        w_cmd.div = 1'b0;
        w_cmd.a   = 32'd0;
        w_cmd.b   = 32'd0;
        w_cmd.d   = 32'd1;
        case (r_op)
            OP_SWEEP: begin
                w_cmd.div = 1'b1;
                w_cmd.a   = n_diff;
                w_cmd.b   = (r_len > 20'd1) ? {12'd0, r_f} : 32'd0;
                w_cmd.d   = (r_len > 20'd1) ? {12'd0, r_len - 20'd1} : 32'd1;
            end
            OP_LCG: begin
                w_cmd.a = r_noise;
                w_cmd.b = tge_pkg::LCG_MUL;
            end
            OP_NOISE: begin
                w_cmd.div = 1'b1;
                w_cmd.a   = {8'd0, r_noise[31:8]};
                w_cmd.b   = 32'd32768;
                w_cmd.d   = tge_pkg::NOISE_HALF;
            end
            OP_ENV: begin
                if (n_att_hit) begin
                    w_cmd.div = 1'b1;
                    w_cmd.a   = {12'd0, r_f};
                    w_cmd.b   = 32'd32768;
                    w_cmd.d   = {12'd0, r_att};
                end else if (n_dec_hit) begin
                    w_cmd.div = 1'b1;
                    w_cmd.a   = {15'd0, n_dec_amt};
                    w_cmd.b   = {12'd0, r_f - r_att};
                    w_cmd.d   = {12'd0, r_dec};
                end else if (n_sus_hit) begin
                    w_cmd.a = {16'd0, r_sus};
                    w_cmd.b = 32'd1;
                end else if (n_rel_hit) begin
                    w_cmd.div = 1'b1;
                    w_cmd.a   = {16'd0, r_sus};
                    w_cmd.b   = {12'd0, r_len - r_f};
                    w_cmd.d   = {12'd0, r_len - n_rel_start};
                end
            end
            OP_MUL1: begin
                w_cmd.a = {15'd0, n_wabs};
                w_cmd.b = {15'd0, r_g};
            end
            OP_MUL2: begin
                w_cmd.a = r_p1;
                w_cmd.b = {16'd0, r_amp};
            end
            default: w_cmd.go = 1'b0;
        endcase
    end

    // Final scaling, saturation and end-of-note test.
    always_comb begin
        n_mag_full = w_rsp.p[63:30];
        n_mag      = (n_mag_full > 34'd32768) ? 16'h8000 : n_mag_full[15:0];
        if (r_wneg) begin
            n_smp = 16'd0 - n_mag;
        end else begin
            n_smp = (n_mag > 16'h7FFF) ? 16'h7FFF : n_mag;
        end
        n_f_inc = {1'b0, r_f} + 21'd1;
        n_last  = (n_f_inc >= {1'b0, r_len});
    end

    // Control state, note state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape     <= 3'd0;
            r_start     <= 32'd0;
            r_end       <= 32'd0;
            r_amp       <= 16'd0;
            r_att       <= 20'd0;
            r_dec       <= 20'd0;
            r_sus       <= 16'h8000;
            r_rel       <= 20'd0;
            r_state     <= S_IDLE;
            r_op        <= OP_SWEEP;
            r_active    <= 1'b0;
            r_f         <= 20'd0;
            r_len       <= 20'd0;
            r_phase     <= 32'd0;
            r_noise     <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tge_pkg::CFG_WAVE_SHAPE: r_shape <= i_cfg_data[2:0];
                    tge_pkg::CFG_START_STEP: r_start <= i_cfg_data;
                    tge_pkg::CFG_END_STEP:   r_end   <= i_cfg_data;
                    tge_pkg::CFG_AMPLITUDE:  r_amp   <= i_cfg_data[15:0];
                    tge_pkg::CFG_ATTACK:     r_att   <= i_cfg_data[19:0];
                    tge_pkg::CFG_DECAY:      r_dec   <= i_cfg_data[19:0];
                    tge_pkg::CFG_SUSTAIN:    r_sus   <= i_cfg_data[15:0];
                    tge_pkg::CFG_RELEASE:    r_rel   <= i_cfg_data[19:0];
                    default:                 r_shape <= r_shape;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.kind == tge_pkg::KIND_START) begin
                            r_len    <= (i_in_data.note_frames == 20'd0) ? 20'd1
                                                                         : i_in_data.note_frames;
                            r_f      <= 20'd0;
                            r_phase  <= 32'd0;
                            r_noise  <= (i_in_data.noise_seed == 32'd0) ? 32'd1
                                                                        : i_in_data.noise_seed;
                            r_active <= 1'b1;
                        end else if (r_active) begin
                            r_op    <= OP_SWEEP;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= S_ISSUE;
                        case (r_op)
                            OP_SWEEP: begin
                                r_phase <= r_phase + n_step;
                                r_op    <= (r_shape == tge_pkg::SHAPE_NOISE) ? OP_LCG : OP_ENV;
                            end
                            OP_LCG: begin
                                r_noise <= w_rsp.p[31:0] + tge_pkg::LCG_ADD;
                                r_op    <= OP_NOISE;
                            end
                            OP_NOISE: r_op <= OP_ENV;
                            OP_ENV:   r_op <= OP_MUL1;
                            OP_MUL1:  r_op <= OP_MUL2;
                            OP_MUL2:  r_state <= S_OUT;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_active    <= !n_last;
                        r_f         <= n_last ? 20'd0 : n_f_inc[19:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working values and the output word.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ISSUE && r_op == OP_ENV) begin
            r_env_base <= (!n_att_hit && n_dec_hit) ? tge_pkg::UNITY_Q15 : 17'd0;
            r_env_sub  <= !n_att_hit && n_dec_hit && !r_sus[15];
        end
        if (r_state == S_ISSUE && r_op == OP_MUL1) begin
            r_wneg <= n_wave[17];
        end
        if (r_state == S_WAIT && w_rsp.done) begin
            case (r_op)
                OP_NOISE: r_nq  <= w_rsp.p[16:0];
                OP_ENV:   r_g   <= n_gain;
                OP_MUL1:  r_p1  <= w_rsp.p[31:0];
                OP_MUL2:  r_smp <= n_smp;
                default:  r_p1  <= r_p1;
            endcase
        end
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_data.sample <= r_smp;
            r_out_data.last   <= n_last;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A new word is loaded into the output register only from the output state.
    `TGE_ASSERT_IMP(a_out_from_state, $rose(r_out_valid), $past(r_state) == S_OUT, "output word loaded outside the output state")
    // The serial unit is free whenever an operation is issued.
    `TGE_ASSERT_IMP(a_unit_free, r_state == S_ISSUE, !w_rsp.busy, "operation issued while the serial unit is busy")
    // The final frame of a note ends the note and clears the frame count.
    `TGE_ASSERT_NXT(a_last_ends_note, (r_state == S_OUT) && (!r_out_valid || i_out_ready) && n_last, !r_active && (r_f == 20'd0), "note still armed after its last frame")
    // With no note armed the frame count is zero.
    `TGE_ASSERT_IMP(a_idle_frame_zero, !r_active, r_f == 20'd0, "frame count not zero while no note is armed")

endmodule
